// ===== rtl/core/kpd_pkg.sv =====
// Package for the keypad scan debouncer: field widths, config register
// indexes and reset values, and the structs passed between modules.
// No dependencies.
`default_nettype none

package kpd_pkg;

    localparam int LINE_W = 16;   // matrix snapshot width
    localparam int IDX_W  = 4;    // key position width
    localparam int CFG_W  = 4;    // config register width

    // config register indexes
    localparam logic REG_SCORE_CEILING = 1'b0;
    localparam logic REG_CONFIRM_LEVEL = 1'b1;

    localparam logic [CFG_W-1:0] CEILING_RST = 4'd8;
    localparam logic [CFG_W-1:0] CONFIRM_RST = 4'd4;

    // raw key from the priority pick
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } kpd_raw_t;

    // one result word
    typedef struct packed {
        logic             press_event;
        logic [IDX_W-1:0] press_index;
        logic             key_held;
    } kpd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/keypad_scan_debounce_top.sv =====
// Keypad scan debouncer top: input register, priority pick, score update,
// result register. Depends on kpd_pkg, kpd_pick and kpd_track.
// Each word passes the input register, then the result register that drives m_tvalid.
// One word per cycle while m_tready is high; s_tready follows it combinationally.
// Reset (aresetn low, synchronous): no key held, no candidate, score 0,
// ceiling 8, confirm level 4, both channels empty.
`default_nettype none

module keypad_scan_debounce_top import kpd_pkg::*; #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [LINE_W-1:0] s_tdata,   // [15:0] switch_lines
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata    // [0] press_event, [4:1] press_index,
                                              // [5] key_held, [7:6] zero
);

    localparam int KEY_COUNT = ROWS * COLS;
    localparam int SCAN_BITS = (KEY_COUNT < LINE_W) ? KEY_COUNT : LINE_W;

    logic              in_valid_reg, in_valid_next;
    logic [LINE_W-1:0] lines_reg;
    logic              out_valid_reg, out_valid_next;
    kpd_result_t       res_reg;
    kpd_result_t       res_comb;
    kpd_raw_t          raw;
    logic              out_free, adv, s_acc;

    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_acc)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc)
            lines_reg <= s_tdata;
        if (adv)
            res_reg <= res_comb;
    end

    kpd_pick #(
        .SCAN_BITS (SCAN_BITS)
    ) u_pick (
        .lines (lines_reg),
        .raw   (raw)
    );

    kpd_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .upd_en    (adv),
        .raw       (raw),
        .result    (res_comb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.key_held, res_reg.press_index, res_reg.press_event};

endmodule

`default_nettype wire

// ===== rtl/core/kpd_pick.sv =====
// Priority pick of the first closed switch in row-major order.
// Depends on kpd_pkg.
`default_nettype none

module kpd_pick import kpd_pkg::*; #(
    parameter int SCAN_BITS = 16
) (
    input  wire logic [LINE_W-1:0] lines,
    output kpd_raw_t               raw
);

    // walk from the top so the lowest closed bit wins
    always_comb begin
        raw.valid = 1'b0;
        raw.index = '0;
        for (int i = SCAN_BITS - 1; i >= 0; i--) begin
            if (lines[i]) begin
                raw.valid = 1'b1;
                raw.index = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kpd_track.sv =====
// Debounce state: candidate/held key tracking with a leaky-integrator score,
// plus the two config registers. Depends on kpd_pkg.
`default_nettype none

module kpd_track import kpd_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             upd_en,
    input  wire kpd_raw_t         raw,
    output kpd_result_t           result
);

    logic [CFG_W-1:0] ceiling_reg, confirm_reg;
    logic             held_reg, held_next;
    logic [IDX_W-1:0] held_idx_reg, held_idx_next;
    logic             cand_reg, cand_next;
    logic [IDX_W-1:0] cand_idx_reg, cand_idx_next;
    logic [CFG_W-1:0] score_reg, score_next;
    logic [CFG_W-1:0] score_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= CEILING_RST;
            confirm_reg <= CONFIRM_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCORE_CEILING: ceiling_reg <= cfg_wdata;
                REG_CONFIRM_LEVEL: confirm_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign score_dec = (score_reg != '0) ? score_reg - 1'b1 : '0;

    always_comb begin
        held_next     = held_reg;
        held_idx_next = held_idx_reg;
        cand_next     = cand_reg;
        cand_idx_next = cand_idx_reg;
        score_next    = score_reg;
        result        = '0;
        if (!held_reg) begin
            if (raw.valid) begin
                if (cand_reg && raw.index == cand_idx_reg) begin
                    if (score_reg < ceiling_reg)
                        score_next = score_reg + 1'b1;
                end else begin
                    cand_next     = 1'b1;
                    cand_idx_next = raw.index;
                    score_next    = CFG_W'(1);
                end
            end else begin
                score_next = score_dec;
            end
            if (cand_next && score_next >= confirm_reg) begin
                held_next          = 1'b1;
                held_idx_next      = cand_idx_next;
                score_next         = ceiling_reg;
                result.press_event = 1'b1;
                result.press_index = cand_idx_next;
            end
        end else begin
            if (raw.valid && raw.index == held_idx_reg) begin
                score_next = ceiling_reg;
            end else if (score_dec == '0) begin
                // released: raw key (if any) starts a fresh candidate
                held_next     = 1'b0;
                cand_next     = raw.valid;
                cand_idx_next = raw.valid ? raw.index : '0;
                score_next    = raw.valid ? CFG_W'(1) : '0;
            end else begin
                score_next = score_dec;
            end
        end
        result.key_held = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= 1'b0;
            held_idx_reg <= '0;
            cand_reg     <= 1'b0;
            cand_idx_reg <= '0;
            score_reg    <= '0;
        end else if (upd_en) begin
            held_reg     <= held_next;
            held_idx_reg <= held_idx_next;
            cand_reg     <= cand_next;
            cand_idx_reg <= cand_idx_next;
            score_reg    <= score_next;
        end
    end

    // a press is only reported from the not-held state
    a_press_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en && result.press_event |-> !held_reg)
        else $error("press reported while a key is held");

    // release only happens once the score has run down
    a_release_score: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(held_reg) |-> $past(score_reg) <= CFG_W'(1))
        else $error("key released with score above one");

    // with neither candidate nor held key the score is empty
    a_idle_score: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_reg && !cand_reg |-> score_reg == '0)
        else $error("score nonzero without candidate");

endmodule

`default_nettype wire

// ===== tb/sv/keypad_scan_debounce_checker.sv =====
// Scoreboard for the keypad scan debouncer: tracks config writes and accepted
// snapshots, predicts each result word and compares it with the m_ channel.
// Depends on kpd_pkg.
module keypad_scan_debounce_checker import kpd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [LINE_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    output int                fail_count,
    output int                reports_due
);

    logic [CFG_W-1:0] ceiling_q;
    logic [CFG_W-1:0] confirm_q;
    logic             held_on;
    logic [IDX_W-1:0] held_key;
    logic             cand_on;
    logic [IDX_W-1:0] cand_key;
    logic [CFG_W-1:0] level;

    kpd_result_t key_reports[$];
    int          words_seen;

    // Advances the debounce state by one snapshot, returns the expected word.
    function automatic kpd_result_t debounce_snapshot(input logic [LINE_W-1:0] lines);
        kpd_result_t      res;
        logic             raw_on;
        logic [IDX_W-1:0] raw_key;
        res = '0;
        raw_on = 1'b0;
        raw_key = '0;
        // lowest closed switch wins
        for (int i = LINE_W - 1; i >= 0; i--) begin
            if (lines[i]) begin
                raw_on = 1'b1;
                raw_key = IDX_W'(i);
            end
        end
        if (!held_on) begin
            if (raw_on) begin
                if (cand_on && raw_key == cand_key) begin
                    if (level < ceiling_q)
                        level = level + 1'b1;
                end else begin
                    cand_on = 1'b1;
                    cand_key = raw_key;
                    level = CFG_W'(1);
                end
            end else if (level > 0) begin
                level = level - 1'b1;
            end
            // confirm test runs on empty snapshots too
            if (cand_on && level >= confirm_q) begin
                held_on = 1'b1;
                held_key = cand_key;
                level = ceiling_q;
                res.press_event = 1'b1;
                res.press_index = cand_key;
            end
        end else if (raw_on && raw_key == held_key) begin
            level = ceiling_q;
        end else begin
            if (level > 0)
                level = level - 1'b1;
            if (level == 0) begin
                held_on = 1'b0;
                cand_on = raw_on;
                cand_key = raw_on ? raw_key : '0;
                level = raw_on ? CFG_W'(1) : '0;
            end
        end
        res.key_held = held_on;
        return res;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] result word %0d: %s", $realtime, words_seen, msg);
    endtask

    always @(posedge aclk) begin
        kpd_result_t want;
        kpd_result_t got;
        if (!aresetn) begin
            ceiling_q = CEILING_RST;
            confirm_q = CONFIRM_RST;
            held_on = 1'b0;
            held_key = '0;
            cand_on = 1'b0;
            cand_key = '0;
            level = '0;
            key_reports.delete();
            fail_count = 0;
            words_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_SCORE_CEILING)
                    ceiling_q = cfg_wdata;
                else if (cfg_index == REG_CONFIRM_LEVEL)
                    confirm_q = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                key_reports.push_back(debounce_snapshot(s_tdata));
            if (m_tvalid && m_tready) begin
                got.press_event = m_tdata[0];
                got.press_index = m_tdata[4:1];
                got.key_held    = m_tdata[5];
                if (key_reports.size() == 0) begin
                    log_failure($sformatf("unexpected word event %0b index %0d held %0b",
                                          got.press_event, got.press_index, got.key_held));
                end else begin
                    want = key_reports.pop_front();
                    if (want.press_event != got.press_event ||
                        want.press_index != got.press_index ||
                        want.key_held != got.key_held)
                        log_failure($sformatf(
                            "expected event %0b index %0d held %0b, got event %0b index %0d held %0b",
                            want.press_event, want.press_index, want.key_held,
                            got.press_event, got.press_index, got.key_held));
                end
                words_seen++;
            end
        end
        reports_due = key_reports.size();
    end

    initial begin
        fail_count = 0;
        reports_due = 0;
        ceiling_q = CEILING_RST;
        confirm_q = CONFIRM_RST;
    end

endmodule

// ===== tb/sv/keypad_scan_debounce_top_test.sv =====
// Testbench top for keypad_scan_debounce_top: clock, reset, snapshot and
// register stimulus, output backpressure and the final verdict.
// Depends on kpd_pkg, the block under test and keypad_scan_debounce_checker.
module keypad_scan_debounce_top_test;
    import kpd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 190;
    localparam int PHASE_COUNT  = 9;
    localparam int LONG_HOLD    = 300;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = REG_SCORE_CEILING;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [LINE_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    int fail_count;
    int reports_due;
    int cycle_count = 0;
    int words_sent = 0;
    int burst_left = 0;
    int hold_calls = 0;
    int ceil_now = 8;
    int conf_now = 4;

    keypad_scan_debounce_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    keypad_scan_debounce_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: switches between stall patterns; a hold-off request forces
    // a long stretch of m_tready low so the pipeline backs up.
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int hold_seen = 0;
    int phase_tick = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_seen != hold_calls) begin
                hold_seen = hold_calls;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= (phase_tick % 5 > 1);
                endcase
            end
        end
    end

    // Offers one word, entered and left at a rising edge.
    task automatic push_word(input logic [LINE_W-1:0] lines);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= lines;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Stop sending and wait for every outstanding result word.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (reports_due != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_levels(input int ceil_val, input int conf_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SCORE_CEILING;
        cfg_wdata <= CFG_W'(ceil_val);
        @(posedge aclk);
        cfg_index <= REG_CONFIRM_LEVEL;
        cfg_wdata <= CFG_W'(conf_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ceil_now = ceil_val;
        conf_now = conf_val;
    endtask

    // Snapshot whose first closed switch is key, higher switches random.
    function automatic logic [LINE_W-1:0] key_snapshot(input int key);
        logic [LINE_W-1:0] w;
        w = LINE_W'($urandom) & (16'hFFFF << key);
        w[key] = 1'b1;
        return w;
    endfunction

    // Press with some contact bounce, hold, then release.
    task automatic play_keystroke();
        int key;
        int n;
        key = $urandom_range(0, 15);
        n = $urandom_range(1, conf_now + 3);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0)
                push_word(LINE_W'($urandom));
            else
                push_word(key_snapshot(key));
        end
        repeat ($urandom_range(0, 12)) push_word(key_snapshot(key));
        n = $urandom_range(0, ceil_now + 3);
        repeat (n) push_word(($urandom_range(0, 3) == 0) ? LINE_W'($urandom) : '0);
    endtask

    int plan_ceil[PHASE_COUNT] = '{15, 15, 1, 8, 3, 0, 2, 0, 5};
    int plan_conf[PHASE_COUNT] = '{15, 1, 1, 4, 9, 0, 2, 15, 5};

    initial begin
        int phase_end;
        int pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset levels: confirm key 0 with junk above it
        push_word(16'h0001);
        push_word(16'hFFFF);
        push_word(16'h0001);
        push_word(16'h0003);
        settle();
        // ceiling 1: one miss releases, new candidate 15, then no key
        set_levels(1, 4);
        push_word(16'h0001);
        push_word(16'h8000);
        push_word(16'h0000);
        settle();
        // confirm level 0: candidate with score 0 confirms on an empty snapshot
        set_levels(1, 0);
        push_word(16'h0000);
        push_word(16'h0000);
        push_word(16'h0010);
        push_word(16'h0010);
        settle();
        // ceiling 0: release on first mismatch, fresh candidate still gets 1
        set_levels(0, 0);
        push_word(16'h0010);
        push_word(16'h0020);
        push_word(16'h0020);
        settle();
        // confirm above ceiling: never reached
        set_levels(2, 3);
        push_word(16'h0000);
        push_word(16'h0100);
        push_word(16'h0100);
        push_word(16'h0100);
        settle();
        // lowered confirm level takes effect on the next empty snapshot
        set_levels(2, 1);
        push_word(16'h0000);
        settle();

        for (int ph = 0; ph < PHASE_COUNT + 2; ph++) begin
            if (ph < PHASE_COUNT)
                set_levels(plan_ceil[ph], plan_conf[ph]);
            else
                set_levels($urandom_range(1, 15), $urandom_range(1, 15));
            hold_calls++;
            phase_end = words_sent + PHASE_WORDS - 30;
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    play_keystroke();
                end else if (pick < 17) begin
                    repeat ($urandom_range(1, 8)) push_word(LINE_W'($urandom));
                end else if (pick < 19) begin
                    repeat ($urandom_range(1, 20)) push_word('0);
                end else begin
                    hold_calls++;
                    play_keystroke();
                end
            end
            settle();
        end

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (reports_due != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && reports_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
